>>> rtl/core/critical_node_finder_defines.svh
// Assertion macros for the critical node finder checker
`ifndef CRITICAL_NODE_FINDER_DEFINES_SVH
`define CRITICAL_NODE_FINDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define CNF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define CNF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/cnf_pkg.sv
// Shared constants, types and controller/datapath interface structs
`default_nettype none

package cnf_pkg;

    localparam int MAX_NODES = 32;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int LABEL_W   = 8;

    typedef logic [LABEL_W-1:0]   label_t;
    typedef logic [MAX_NODES-1:0] row_t;
    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;

    typedef enum logic [1:0] {
        OP_ADD     = 2'd0,
        OP_CONNECT = 2'd1,
        OP_ANALYZE = 2'd2
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_LK_RD,
        ST_LK_CMP,
        ST_LK_END,
        ST_ED_RD_P,
        ST_ED_WR_P,
        ST_ED_RD_Q,
        ST_ED_WR_Q,
        ST_TEST_INIT,
        ST_SW_RD,
        ST_SW_ACC,
        ST_EMIT
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic latch_item;
        logic add_write;
        logic lk_read;
        logic lk_cmp;
        logic edge_rd_p;
        logic edge_wr_p;
        logic edge_rd_q;
        logic edge_wr_q;
        logic test_init;
        logic sweep_rd;
        logic sweep_acc;
        logic out_load;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        op_t  op;
        logic count_zero;
        logic full;
        logic j_last;
        logic i_last;
        logic found_both;
        logic sweep_more;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

>>> rtl/core/cnf_ctrl.sv
// Sequencer for add, connect and analyse transactions
`default_nettype none

module cnf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          item_valid,
    output logic               item_stall,
    input  wire cnf_pkg::sts_t sts,
    output cnf_pkg::cmd_t      cmd
);
    import cnf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH:
            begin
                case (sts.op)
                    OP_CONNECT: state_next = sts.count_zero ? ST_IDLE : ST_LK_RD;
                    OP_ANALYZE: state_next = sts.count_zero ? ST_IDLE : ST_TEST_INIT;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_LK_RD:     state_next = ST_LK_CMP;
            ST_LK_CMP:    state_next = sts.j_last ? ST_LK_END : ST_LK_RD;
            ST_LK_END:    state_next = sts.found_both ? ST_ED_RD_P : ST_IDLE;
            ST_ED_RD_P:   state_next = ST_ED_WR_P;
            ST_ED_WR_P:   state_next = ST_ED_RD_Q;
            ST_ED_RD_Q:   state_next = ST_ED_WR_Q;
            ST_ED_WR_Q:   state_next = ST_IDLE;
            ST_TEST_INIT: state_next = ST_SW_RD;
            ST_SW_RD:     state_next = ST_SW_ACC;
            ST_SW_ACC:
            begin
                if (sts.j_last && !sts.sweep_more)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SW_RD;
                end
            end
            ST_EMIT:
            begin
                if (sts.out_free)
                begin
                    state_next = sts.i_last ? ST_IDLE : ST_TEST_INIT;
                end
            end
            default:      state_next = ST_IDLE;
        endcase
    end

    // Command outputs
    always_comb
    begin
        cmd        = '0;
        item_stall = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                item_stall     = 1'b0;
                cmd.latch_item = item_valid;
            end
            ST_DISPATCH:  cmd.add_write = (sts.op == OP_ADD) && !sts.full;
            ST_LK_RD:     cmd.lk_read   = 1'b1;
            ST_LK_CMP:    cmd.lk_cmp    = 1'b1;
            ST_ED_RD_P:   cmd.edge_rd_p = 1'b1;
            ST_ED_WR_P:   cmd.edge_wr_p = 1'b1;
            ST_ED_RD_Q:   cmd.edge_rd_q = 1'b1;
            ST_ED_WR_Q:   cmd.edge_wr_q = 1'b1;
            ST_TEST_INIT: cmd.test_init = 1'b1;
            ST_SW_RD:     cmd.sweep_rd  = 1'b1;
            ST_SW_ACC:    cmd.sweep_acc = 1'b1;
            ST_EMIT:      cmd.out_load  = sts.out_free;
            default:      cmd           = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/core/cnf_datapath.sv
// Node tables, lookup, edge update, reachability sweep and result register
`default_nettype none

module cnf_datapath (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cnf_pkg::cmd_t         cmd,
    output cnf_pkg::sts_t              sts,
    input  wire logic [1:0]            operation,
    input  wire logic [7:0]            name_a,
    input  wire logic [7:0]            name_b,
    input  wire logic                  result_stall,
    output logic                       result_valid,
    output logic [7:0]                 node_label,
    output logic                       is_critical,
    output logic                       last_in_run
);
    import cnf_pkg::*;

    // Storage
    label_t label_mem [MAX_NODES];
    row_t   adj_mem   [MAX_NODES];

    // Item and control registers
    op_t    op_reg;
    label_t a_reg;
    label_t b_reg;
    cnt_t   count_reg;
    idx_t   i_reg;
    idx_t   j_reg;
    idx_t   p_reg;
    idx_t   q_reg;
    logic   p_found_reg;
    logic   q_found_reg;
    row_t   reached_reg;
    row_t   active_reg;
    logic   changed_reg;
    label_t label_rd_reg;
    row_t   adj_rd_reg;

    // Result register
    logic   out_valid_reg;
    label_t out_label_reg;
    logic   out_crit_reg;
    logic   out_last_reg;

    // Memory port selects
    logic   label_re;
    idx_t   label_raddr;
    logic   adj_re;
    idx_t   adj_raddr;
    logic   adj_we;
    idx_t   adj_waddr;
    row_t   adj_wdata;
    idx_t   count_idx;

    // Derived values
    logic [MAX_NODES:0] all_wide;
    logic [MAX_NODES:0] all_wide_m1;
    row_t   all_mask;
    row_t   start_bit;
    row_t   grow_row;
    logic   grow_change;
    logic   match_a;
    logic   match_b;
    logic   j_last;
    logic   i_last;
    logic   out_free;

    assign count_idx   = count_reg[IDX_W-1:0];
    assign all_wide    = (MAX_NODES + 1)'(1) << count_reg;
    assign all_wide_m1 = all_wide - (MAX_NODES + 1)'(1);
    assign all_mask    = all_wide_m1[MAX_NODES-1:0];
    assign start_bit   = (i_reg == '0) ? row_t'(2) : row_t'(1);
    assign j_last      = (CNT_W'(j_reg) == (count_reg - CNT_W'(1)));
    assign i_last      = (CNT_W'(i_reg) == (count_reg - CNT_W'(1)));
    assign match_a     = (label_rd_reg == a_reg);
    assign match_b     = (label_rd_reg == b_reg);
    assign out_free    = !out_valid_reg || !result_stall;

    // One sweep step: neighbours of a reached node join the set
    assign grow_row    = reached_reg | (adj_rd_reg & active_reg);
    assign grow_change = reached_reg[j_reg] && (grow_row != reached_reg);

    // Memory port selection
    always_comb
    begin
        label_re    = cmd.lk_read | cmd.test_init;
        label_raddr = cmd.test_init ? i_reg : j_reg;
        adj_re      = cmd.sweep_rd | cmd.edge_rd_p | cmd.edge_rd_q;
        adj_raddr   = j_reg;
        if (cmd.edge_rd_p)
        begin
            adj_raddr = p_reg;
        end
        else if (cmd.edge_rd_q)
        begin
            adj_raddr = q_reg;
        end
        adj_we    = cmd.add_write | cmd.edge_wr_p | cmd.edge_wr_q;
        adj_waddr = count_idx;
        adj_wdata = '0;
        if (cmd.edge_wr_p)
        begin
            adj_waddr = p_reg;
            adj_wdata = adj_rd_reg | (row_t'(1) << q_reg);
        end
        else if (cmd.edge_wr_q)
        begin
            adj_waddr = q_reg;
            adj_wdata = adj_rd_reg | (row_t'(1) << p_reg);
        end
    end

    // Label and adjacency memories, registered reads
    always_ff @(posedge clk)
    begin
        if (cmd.add_write)
        begin
            label_mem[count_idx] <= a_reg;
        end
        if (label_re)
        begin
            label_rd_reg <= label_mem[label_raddr];
        end
        if (adj_we)
        begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re)
        begin
            adj_rd_reg <= adj_mem[adj_raddr];
        end
    end

    // Node count and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.add_write)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Item latch, counters, lookup and sweep registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_item)
        begin
            op_reg      <= op_t'(operation);
            a_reg       <= name_a;
            b_reg       <= name_b;
            i_reg       <= '0;
            j_reg       <= '0;
            p_found_reg <= 1'b0;
            q_found_reg <= 1'b0;
        end
        // first matching slot wins
        if (cmd.lk_cmp)
        begin
            if (!p_found_reg && match_a)
            begin
                p_reg       <= j_reg;
                p_found_reg <= 1'b1;
            end
            if (!q_found_reg && match_b)
            begin
                q_reg       <= j_reg;
                q_found_reg <= 1'b1;
            end
        end
        if (cmd.lk_cmp || cmd.sweep_acc)
        begin
            j_reg <= j_last ? '0 : j_reg + IDX_W'(1);
        end
        // start a test with node i removed
        if (cmd.test_init)
        begin
            active_reg  <= all_mask & ~(row_t'(1) << i_reg);
            reached_reg <= start_bit & all_mask & ~(row_t'(1) << i_reg);
            changed_reg <= 1'b0;
            j_reg       <= '0;
        end
        if (cmd.sweep_acc)
        begin
            if (reached_reg[j_reg])
            begin
                reached_reg <= grow_row;
            end
            changed_reg <= j_last ? 1'b0 : (changed_reg | grow_change);
        end
        if (cmd.out_load)
        begin
            out_label_reg <= label_rd_reg;
            out_crit_reg  <= (reached_reg != active_reg);
            out_last_reg  <= i_last;
            i_reg         <= i_reg + IDX_W'(1);
        end
    end

    // Status to controller
    always_comb
    begin
        sts.op         = op_reg;
        sts.count_zero = (count_reg == '0);
        sts.full       = (count_reg == CNT_W'(MAX_NODES));
        sts.j_last     = j_last;
        sts.i_last     = i_last;
        sts.found_both = p_found_reg && q_found_reg;
        sts.sweep_more = changed_reg | grow_change;
        sts.out_free   = out_free;
    end

    assign result_valid = out_valid_reg;
    assign node_label   = out_label_reg;
    assign is_critical  = out_crit_reg;
    assign last_in_run  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/core/critical_node_finder.sv
// Critical node finder: top level joining controller and datapath
//
// Loads an undirected graph of up to 32 labelled nodes and reports, per node
// in insertion order, whether removing it disconnects the rest. Item input is
// stalled while a transaction is in progress. An add is accepted, then written
// at dispatch unless the store is full. A connect compares each stored label
// with both names, a read step and a compare step per node, then checks the
// result, and when both labels are found updates both adjacency rows (a read
// and a write for each); with no stored node it ends after dispatch, as does an
// analyse. An analyse runs one test per node: each test initialises, then
// repeats adjacency sweeps until the reached set stops growing (at most N
// sweeps, with N the stored node count), each sweep reading one adjacency row
// at a time, a read then an accumulate, from the single-read-port row memory,
// then loads the result register, which waits while the result is stalled.
// The label and adjacency stores are not cleared at reset; no clearing pass runs.
`default_nettype none

module critical_node_finder (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] operation,
    input  wire logic [7:0] name_a,
    input  wire logic [7:0] name_b,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [7:0]      node_label,
    output logic            is_critical,
    output logic            last_in_run
);
    import cnf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cnf_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .sts        (sts),
        .cmd        (cmd)
    );

    cnf_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .operation    (operation),
        .name_a       (name_a),
        .name_b       (name_b),
        .result_stall (result_stall),
        .result_valid (result_valid),
        .node_label   (node_label),
        .is_critical  (is_critical),
        .last_in_run  (last_in_run)
    );

endmodule

`default_nettype wire

>>> rtl/core/cnf_checker.sv
// Port-level assertions for the critical node finder, bound to the top level
`default_nettype none
`include "critical_node_finder_defines.svh"

module cnf_checker (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       item_valid,
    input wire logic       item_stall,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic [7:0] node_label,
    input wire logic       is_critical,
    input wire logic       last_in_run
);

    // a stalled result holds
    `CNF_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(node_label) && $stable(is_critical) && $stable(last_in_run), "stalled result changed")

    // the input is stalled in the cycle after every accepted item
    `CNF_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, item_valid && !item_stall, item_stall, "input taken on consecutive cycles")

    // a run is still busy while a non-final result is pending
    `CNF_ASSERT_NOW(a_busy_mid_run, clk, rst_n, result_valid && !last_in_run, item_stall, "input open in the middle of a run")

    // nothing follows the final result of a run straight away
    `CNF_ASSERT_NEXT(a_quiet_after_last, clk, rst_n, result_valid && last_in_run && !result_stall, !result_valid, "result straight after end of run")

endmodule

bind critical_node_finder cnf_checker u_cnf_checker (.*);

`default_nettype wire
